// File: rtl/fbpa_pkg.sv
// Shared types and constants for the fixed-size block pool allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fbpa_pkg;

	localparam int ADDR_W      = 32;
	localparam int BLOCK_W     = 16;
	localparam int FREE_W      = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;

	localparam logic [BLOCK_W-1:0]   MIN_BLOCK_SIZE = 16'd8;
	localparam logic [BLOCK_W-1:0]   RST_BLOCK_SIZE = 16'd64;
	localparam logic [ADDR_W-1:0]    RST_POOL_BASE  = 32'd0;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 1'b1;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_GRANTED    = 3'd0,
		ST_TOO_LARGE  = 3'd1,
		ST_POOL_EMPTY = 3'd2,
		ST_RETURNED   = 3'd3,
		ST_OUTSIDE    = 3'd4,
		ST_LIST_FULL  = 3'd5
	} status_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [BLOCK_W-1:0]  request_size;
		logic [ADDR_W-1:0]   release_address;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [ADDR_W-1:0]   granted_address;
		logic [FREE_W-1:0]   free_blocks;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
		logic pop;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/fbpa_ctrl.sv
// Request sequencer of the block pool allocator: capture, execute, read-back.
// Depends on fbpa_pkg for the state and command/status types.
`default_nettype none

module fbpa_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  fbpa_pkg::dp_stat_t stat,
	output fbpa_pkg::cmd_t    cmd
);
	import fbpa_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.finish  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the result register can take a result
				if (stat.out_free) begin
					cmd.exec  = 1'b1;
					state_nxt = stat.pop ? S_READ : S_IDLE;
				end
			end
			S_READ: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/fbpa_dp.sv
// Datapath of the block pool allocator: config registers, free-list memory,
// stack counters and result register. Depends on fbpa_pkg.
`default_nettype none

module fbpa_dp #(
	parameter int CAPACITY = 64
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  fbpa_pkg::cmd_t                       cmd,
	output fbpa_pkg::dp_stat_t                   stat,
	input  fbpa_pkg::req_t                       in_data,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output fbpa_pkg::rsp_t                       out_data,
	input  wire                                  cfg_we,
	input  wire [fbpa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [fbpa_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import fbpa_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OFF_W = $clog2(CAPACITY) + BLOCK_W;

	localparam logic [CNT_W-1:0] CAP_CNT     = CNT_W'(CAPACITY);
	localparam logic [OFF_W-1:0] CAP_K       = OFF_W'(CAPACITY);
	localparam logic [OFF_W-1:0] CAP_M1_K    = OFF_W'(CAPACITY - 1);
	localparam logic [OFF_W-1:0] RST_SPAN    = OFF_W'(CAPACITY * 64);
	localparam logic [OFF_W-1:0] RST_LOW_OFF = OFF_W'((CAPACITY - 1) * 64);

	// config and list state
	logic [ADDR_W-1:0]  base_q;
	logic [BLOCK_W-1:0] bs_q;
	logic [OFF_W-1:0]   span_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   low_q;      // lowest fill since the last rebuild
	logic [OFF_W-1:0]   low_off_q;  // rebuilt offset of slot low_q-1

	logic [OFF_W-1:0]   mem [CAPACITY];
	logic [OFF_W-1:0]   rdata_q;

	req_t               req_q;
	logic               pop_rebuild_q;
	logic [OFF_W-1:0]   pop_off_q;
	rsp_t               out_q;
	logic               out_valid_q;

	// config write
	logic [BLOCK_W-1:0] cfg_bs;
	logic [BLOCK_W-1:0] bs_wr;
	logic [OFF_W-1:0]   span_nxt;
	logic [OFF_W-1:0]   low_off_nxt;

	// request decode
	logic               alloc;
	logic               too_large;
	logic               empty;
	logic               full;
	logic [ADDR_W-1:0]  diff;
	logic               in_pool;
	logic               pop;
	logic               push;
	logic               from_rebuild;
	logic [CNT_W-1:0]   top_cnt;
	logic [CNT_W-1:0]   count_nxt;
	status_t            status;
	logic [OFF_W-1:0]   grant_off;

	always_comb begin
		cfg_bs      = cfg_data[BLOCK_W-1:0];
		bs_wr       = bs_q;
		if (cfg_index == REG_BLOCK_SIZE) begin
			bs_wr = (cfg_bs < MIN_BLOCK_SIZE) ? MIN_BLOCK_SIZE : cfg_bs;
		end
		span_nxt    = CAP_K * OFF_W'(bs_wr);
		low_off_nxt = CAP_M1_K * OFF_W'(bs_wr);
	end

	always_comb begin
		alloc        = (req_q.opcode == OP_ALLOC);
		too_large    = req_q.request_size > bs_q;
		empty        = (count_q == '0);
		full         = (count_q == CAP_CNT);
		diff         = req_q.release_address - base_q;
		in_pool      = (req_q.release_address >= base_q) && (diff < ADDR_W'(span_q));
		pop          = alloc && !too_large && !empty;
		push         = !alloc && in_pool && !full;
		from_rebuild = (count_q == low_q);
		top_cnt      = count_q - CNT_W'(1);
		count_nxt    = count_q;
		if (pop) begin
			count_nxt = count_q - CNT_W'(1);
		end else if (push) begin
			count_nxt = count_q + CNT_W'(1);
		end
		if (alloc) begin
			if (too_large) begin
				status = ST_TOO_LARGE;
			end else if (empty) begin
				status = ST_POOL_EMPTY;
			end else begin
				status = ST_GRANTED;
			end
		end else begin
			if (!in_pool) begin
				status = ST_OUTSIDE;
			end else if (full) begin
				status = ST_LIST_FULL;
			end else begin
				status = ST_RETURNED;
			end
		end
		grant_off = pop_rebuild_q ? pop_off_q : rdata_q;
	end

	// config registers and stack counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= RST_POOL_BASE;
			bs_q      <= RST_BLOCK_SIZE;
			span_q    <= RST_SPAN;
			count_q   <= CAP_CNT;
			low_q     <= CAP_CNT;
			low_off_q <= RST_LOW_OFF;
		end else if (cfg_we) begin
			// any write rebuilds the full list
			unique case (cfg_index)
				REG_POOL_BASE:  base_q <= cfg_data[ADDR_W-1:0];
				REG_BLOCK_SIZE: bs_q   <= bs_wr;
			endcase
			span_q    <= span_nxt;
			count_q   <= CAP_CNT;
			low_q     <= CAP_CNT;
			low_off_q <= low_off_nxt;
		end else if (cmd.exec) begin
			count_q <= count_nxt;
			if (pop && from_rebuild) begin
				low_q     <= low_q - CNT_W'(1);
				low_off_q <= low_off_q - OFF_W'(bs_q);
			end
		end
	end

	// free-list memory
	always_ff @(posedge clk) begin
		if (cmd.exec && push) begin
			mem[count_q[IDX_W-1:0]] <= diff[OFF_W-1:0];
		end
		if (cmd.exec && pop) begin
			rdata_q <= mem[top_cnt[IDX_W-1:0]];
		end
	end

	// request capture and pop bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= in_data;
		end
		if (cmd.exec && pop) begin
			pop_rebuild_q <= from_rebuild;
			pop_off_q     <= low_off_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec && !pop) begin
			out_q.status          <= status;
			out_q.granted_address <= '0;
			out_q.free_blocks     <= FREE_W'(count_nxt);
		end else if (cmd.finish) begin
			out_q.status          <= ST_GRANTED;
			out_q.granted_address <= base_q + ADDR_W'(grant_off);
			out_q.free_blocks     <= FREE_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.exec && !pop) || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.pop      = pop;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

endmodule

`default_nettype wire

// File: rtl/fixed_block_pool_allocator_unit.sv
// Fixed-size block pool allocator: LIFO free list of byte offsets.
// A result is registered by the exec step, or by the finish step for a pop; both
// hold while the result register is full. A new request is taken only in idle.
// Reset: base 0, block size 64, list full; no clearing pass, a low-water mark
// serves never-written slots. Depends on fbpa_pkg, fbpa_ctrl and fbpa_dp.
`default_nettype none

module fixed_block_pool_allocator_unit #(
	parameter int CAPACITY = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  fbpa_pkg::req_t                   in_data,
	output logic                             out_valid,
	input  wire                              out_ready,
	output fbpa_pkg::rsp_t                   out_data,
	input  wire                              cfg_we,
	input  wire [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [fbpa_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fbpa_pkg::*;

	// The controller walks each request through three steps:
	//   capture - latch the request on its transfer
	//   exec    - classify it, move the stack top, push into the list memory,
	//             and load the result register unless it pops
	//   finish  - for a pop, add the offset read from the list memory (or the
	//             rebuilt offset below the low-water mark) to the pool base
	// The result register stays valid until its transfer, while the next
	// request may already be captured; exec and finish hold while it is full.
	cmd_t     cmd;
	dp_stat_t stat;

	fbpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Slots at or above the lowest fill level reached since the last rebuild
	// have been rewritten by pushes; slots below it still hold k * block_size.
	fbpa_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for fixed_block_pool_allocator_unit: directed corner cases,
// then random allocate/release traffic, each checked against a cycle-free shadow pool.
// Depends on fbpa_pkg and the allocator RTL; reads nothing else.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fbpa_pkg::*;

	localparam int POOL_BLOCKS  = 64;
	localparam int LIMIT_CYCLES = 150_000;
	localparam int SETTLE_GAP   = 6;
	localparam int RANDOM_ITEMS = 175;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	req_t                  in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	rsp_t                  out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	fixed_block_pool_allocator_unit #(
		.CAPACITY(POOL_BLOCKS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the pool: configuration plus the LIFO of byte offsets.
	logic [ADDR_W-1:0]  shadow_base;
	logic [BLOCK_W-1:0] shadow_block_size;
	logic [ADDR_W-1:0]  shadow_offsets [POOL_BLOCKS];
	int                 shadow_top;

	// Responses predicted at request transfer, oldest first.
	rsp_t               pending_responses [$];
	// Addresses currently handed out, and recently returned ones for double releases.
	logic [ADDR_W-1:0]  held_blocks [$];
	logic [ADDR_W-1:0]  returned_blocks [$];

	int                 mismatch_count = 0;
	int                 cycle_count = 0;
	bit                 steady_traffic = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: end the run if the handshakes ever stall for good.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: stall about a quarter of the cycles, never during a steady stretch.
	always @(posedge clk) begin
		if (steady_traffic)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 99) >= 26);
	end

	// Refill the shadow list with every block; block POOL_BLOCKS-1 ends up on top.
	function automatic void rebuild_shadow_list();
		for (int k = 0; k < POOL_BLOCKS; k++)
			shadow_offsets[k] = k * shadow_block_size;
		shadow_top = POOL_BLOCKS;
	endfunction

	function automatic longint unsigned pool_span();
		return longint'(POOL_BLOCKS) * longint'(shadow_block_size);
	endfunction

	// Apply one request to the shadow pool and return the response it must produce.
	function automatic rsp_t predict_pool_response(input req_t r);
		rsp_t              p;
		logic [ADDR_W-1:0] offset;
		bit                in_pool;
		p = '0;
		if (r.opcode == OP_ALLOC) begin
			if (r.request_size > shadow_block_size) begin
				p.status = ST_TOO_LARGE;
			end else if (shadow_top == 0) begin
				p.status = ST_POOL_EMPTY;
			end else begin
				shadow_top--;
				p.granted_address = shadow_base + shadow_offsets[shadow_top];
				p.status = ST_GRANTED;
			end
		end else begin
			// Membership bound is taken without wrap: a pool running past the top
			// of the address space simply ends there.
			in_pool = 1'b0;
			offset = '0;
			if (r.release_address >= shadow_base) begin
				offset = r.release_address - shadow_base;
				in_pool = (longint'(offset) < pool_span());
			end
			if (!in_pool) begin
				p.status = ST_OUTSIDE;
			end else if (shadow_top >= POOL_BLOCKS) begin
				p.status = ST_LIST_FULL;
			end else begin
				// Unaligned offsets go on the list untouched.
				shadow_offsets[shadow_top] = offset;
				shadow_top++;
				p.status = ST_RETURNED;
			end
		end
		p.free_blocks = shadow_top[FREE_W-1:0];
		return p;
	endfunction

	// Build requests; the field that the operation ignores carries random bits.
	function automatic req_t alloc_req(input logic [BLOCK_W-1:0] size);
		req_t r;
		r.opcode = OP_ALLOC;
		r.request_size = size;
		r.release_address = $urandom;
		return r;
	endfunction

	function automatic req_t release_req(input logic [ADDR_W-1:0] addr);
		req_t r;
		r.opcode = OP_RELEASE;
		r.request_size = 16'($urandom);
		r.release_address = addr;
		return r;
	endfunction

	// Present one request, hold it until the transfer, then record its prediction.
	task automatic transfer_request(input req_t r);
		rsp_t predicted;
		if (!steady_traffic && $urandom_range(0, 99) < 26) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = predict_pool_response(r);
		pending_responses.push_back(predicted);
		if (predicted.status == ST_GRANTED)
			held_blocks.push_back(predicted.granted_address);
		else if (predicted.status == ST_RETURNED) begin
			returned_blocks.push_back(r.release_address);
			if (returned_blocks.size() > 32)
				void'(returned_blocks.pop_front());
		end
	endtask

	// Hold off the sender until every predicted response has come back.
	task automatic drain_responses();
		in_valid <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
		repeat (SETTLE_GAP) @(posedge clk);
	endtask

	// Write one register while idle; any write rebuilds the free list.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		logic [BLOCK_W-1:0] size_field;
		drain_responses();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_POOL_BASE) begin
			shadow_base = value;
		end else begin
			size_field = value[BLOCK_W-1:0];
			shadow_block_size = (size_field < MIN_BLOCK_SIZE) ? MIN_BLOCK_SIZE : size_field;
		end
		rebuild_shadow_list();
		held_blocks.delete();
		returned_blocks.delete();
	endtask

	task automatic configure_pool(input logic [ADDR_W-1:0] base,
			input logic [CFG_DATA_W-1:0] size_word);
		write_register(REG_POOL_BASE, base);
		write_register(REG_BLOCK_SIZE, size_word);
	endtask

	// Response checker: compare every transfer with the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_responses.size() == 0) begin
				$display("%0t ns: unexpected response, expected none got status %0d addr %h free %0d",
					$time, out_data.status, out_data.granted_address, out_data.free_blocks);
				mismatch_count++;
			end else begin
				want = pending_responses.pop_front();
				if (out_data.status !== want.status) begin
					$display("%0t ns: status expected %0d got %0d",
						$time, want.status, out_data.status);
					mismatch_count++;
				end
				if (out_data.granted_address !== want.granted_address) begin
					$display("%0t ns: granted_address expected %h got %h",
						$time, want.granted_address, out_data.granted_address);
					mismatch_count++;
				end
				if (out_data.free_blocks !== want.free_blocks) begin
					$display("%0t ns: free_blocks expected %0d got %0d",
						$time, want.free_blocks, out_data.free_blocks);
					mismatch_count++;
				end
			end
		end
	end

	// Reset configuration: size limits, double release, full list, outside addresses,
	// unaligned release. No register write yet, so reset values are checked too.
	task automatic test_reset_state_and_limits();
		transfer_request(alloc_req(16'd0));
		transfer_request(alloc_req(16'd64));      // exactly block size fits
		transfer_request(alloc_req(16'd65));      // one byte too many
		transfer_request(alloc_req(16'hFFFF));
		transfer_request(release_req(32'd4032));  // top block back
		transfer_request(release_req(32'd4032));  // double release with room
		transfer_request(release_req(32'd0));     // list full, drop
		transfer_request(release_req(32'd4096));  // first byte past the pool
		transfer_request(release_req(32'hFFFF_FFFF));
		transfer_request(alloc_req(16'd16));
		transfer_request(release_req(32'd4095));  // unaligned, last byte of pool
		transfer_request(alloc_req(16'd1));
	endtask

	// Block size clamp and a pool that runs past the top of the address space.
	task automatic test_clamp_and_wrap();
		configure_pool(32'h0000_1000, 32'hFFFF_0000);  // size field 0 clamps to 8
		transfer_request(alloc_req(16'd8));
		transfer_request(alloc_req(16'd9));
		transfer_request(release_req(32'h0000_0FFF));  // one below base
		transfer_request(release_req(32'h0000_11FF));  // last byte, unaligned
		transfer_request(release_req(32'h0000_1200));
		write_register(REG_BLOCK_SIZE, 32'd7);
		configure_pool(32'hFFFF_FF00, 32'd16);
		transfer_request(alloc_req(16'd16));           // address wraps past zero
		transfer_request(release_req(32'hFFFF_FFFF));
		transfer_request(release_req(32'h0000_02F0));  // wrapped grant lies below base
		transfer_request(alloc_req(16'd17));
		configure_pool(32'hFFFF_FFFF, 32'h0000_FFFF);
		transfer_request(alloc_req(16'hFFFF));
		transfer_request(release_req(32'd0));
		transfer_request(release_req(32'hFFFF_FFFF));
	endtask

	// Drain the pool past empty, then return every block and release twice more.
	task automatic test_exhaust_and_refill();
		int pick;
		configure_pool($urandom, {16'h0000, 16'($urandom_range(8, 256))});
		for (int n = 0; n < POOL_BLOCKS + 3; n++)
			transfer_request(alloc_req(16'($urandom_range(0, shadow_block_size))));
		while (held_blocks.size() != 0) begin
			pick = $urandom_range(0, held_blocks.size() - 1);
			transfer_request(release_req(held_blocks[pick]));
			held_blocks.delete(pick);
		end
		transfer_request(release_req(returned_blocks[0]));
		transfer_request(release_req(returned_blocks[$]));
	endtask

	// One random request, leaning toward allocation by alloc_share percent.
	task automatic random_request(input int alloc_share);
		int                unsigned span;
		int                roll;
		int                pick;
		logic [ADDR_W-1:0] addr;
		span = POOL_BLOCKS * shadow_block_size;
		roll = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < alloc_share) begin
			if (roll < 80)
				transfer_request(alloc_req(16'($urandom_range(0, shadow_block_size))));
			else if (roll < 90)
				transfer_request(alloc_req(16'($urandom)));
			else
				transfer_request(alloc_req(shadow_block_size + 16'($urandom_range(0, 1))));
		end else begin
			if (roll < 70 && held_blocks.size() != 0) begin
				pick = $urandom_range(0, held_blocks.size() - 1);
				addr = held_blocks[pick];
				held_blocks.delete(pick);
			end else if (roll < 80) begin
				addr = shadow_base + $urandom_range(0, span - 1);
			end else if (roll < 90) begin
				case ($urandom_range(0, 2))
					0: addr = shadow_base - 1 - $urandom_range(0, 1023);
					1: addr = shadow_base + span + $urandom_range(0, 1023);
					default: addr = $urandom;
				endcase
			end else if (returned_blocks.size() != 0) begin
				addr = returned_blocks[$urandom_range(0, returned_blocks.size() - 1)];
			end else begin
				addr = $urandom;
			end
			transfer_request(release_req(addr));
		end
	endtask

	// Several pool settings, extremes among them. Each phase swings between
	// allocation-heavy and release-heavy stretches so the list runs empty and full.
	task automatic test_random_traffic();
		logic [ADDR_W-1:0]     bases [6];
		logic [CFG_DATA_W-1:0] sizes [6];
		bases = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FF80, $urandom, $urandom, $urandom};
		sizes = '{32'd64, 32'h0000_FFFF, 32'd8, {16'($urandom), 16'd3},
			32'($urandom_range(8, 4096)), $urandom};
		for (int ph = 0; ph < 6; ph++) begin
			configure_pool(bases[ph], sizes[ph]);
			steady_traffic = (ph == 0);
			for (int n = 0; n < RANDOM_ITEMS; n++) begin
				if (n == RANDOM_ITEMS / 2)
					drain_responses();
				random_request(((n / 50) % 2 == 0) ? 75 : 25);
			end
			steady_traffic = 1'b0;
		end
	endtask

	initial begin
		shadow_base = RST_POOL_BASE;
		shadow_block_size = RST_BLOCK_SIZE;
		rebuild_shadow_list();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state_and_limits();
		test_clamp_and_wrap();
		test_exhaust_and_refill();
		test_random_traffic();

		// Drop valid, wait out the remaining responses, then allow stragglers to show.
		drain_responses();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
